@@ rtl/core/stfm_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Speaker tone frequency meter package
// Transfer types, command codes and fixed field widths shared by the core.
// ----------------------------------------------------------------------------
package stfm_pkg;

  localparam int FREQ_W   = 26;
  localparam int TIME_W   = 32;
  localparam int MODE_LSB = 3;

  localparam logic [FREQ_W-1:0] FREQ_MAX = {FREQ_W{1'b1}};

  typedef enum logic [1:0] {
    CMD_WRITE = 2'd0,
    CMD_SYNC  = 2'd1,
    CMD_RESET = 2'd2,
    CMD_NOP   = 2'd3
  } cmd_code_t;

  typedef struct packed {
    logic [1:0]        command;
    logic [7:0]        latch_data;
    logic [TIME_W-1:0] cycle_time;
  } cmd_t;

  typedef struct packed {
    logic [FREQ_W-1:0] tone_frequency;
    logic [7:0]        latch_value;
    logic [1:0]        video_mode;
  } res_t;

  typedef struct packed {
    logic done;
    logic saturated;
  } div_status_t;

endpackage

@@ rtl/core/speaker_tone_frequency_meter_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Speaker tone frequency meter
// Control latch model with speaker toggle timing and frequency estimate.
// ----------------------------------------------------------------------------
// Usage:
//   cmd channel takes one command per transfer (latch write, frame sync,
//   reset, no-op); res channel returns exactly one result per command:
//   frequency in Hz, latch byte and video mode bits.
//   A latch write, reset, no-op or a sync without a valid measurement goes
//   from acceptance straight to the finish state, which registers its result.
//   A sync with a measurement runs a 21x32 multiply and then a restoring
//   divider that yields one quotient bit per cycle for the 26-bit quotient; a
//   saturating quotient is found at divider start. The divider loop sets the
//   sync throughput. cmd_stall is high while a command is in work. The result
//   sits in an output register, so the next command is taken while res is
//   stalled; that command then waits for the register before finishing.
//   rst clears the latch, the measurement, the frequency and both channels.
// ----------------------------------------------------------------------------
module speaker_tone_frequency_meter_top #(
  parameter int CYCLES_PER_SECOND = 3546900
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            cmd_valid,
  output logic            cmd_stall,
  input  stfm_pkg::cmd_t  cmd,
  output logic            res_valid,
  input  logic            res_stall,
  output stfm_pkg::res_t  res
);

  localparam int FW     = stfm_pkg::FREQ_W;
  localparam int TW     = stfm_pkg::TIME_W;
  localparam int HALF_W = $clog2(CYCLES_PER_SECOND / 2 + 1);
  localparam int PROD_W = HALF_W + TW;
  localparam logic [HALF_W-1:0] HALF_RATE = HALF_W'(CYCLES_PER_SECOND / 2);

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_MUL  = 5'b00010,
    ST_DIVS = 5'b00100,
    ST_DIVW = 5'b01000,
    ST_FIN  = 5'b10000
  } state_t;

  state_t state;

  logic [7:0]     latch_byte;
  logic [TW-1:0]  last_toggle_time;
  logic [TW-1:0]  toggle_count;
  logic [TW-1:0]  gap_total;
  logic [FW-1:0]  frequency_reg;
  logic [PROD_W-1:0] product;

  logic               accept;
  logic               toggle;
  logic [TW-1:0]      gap;
  logic               eligible;
  logic               res_free;
  logic [FW-1:0]      quotient;
  stfm_pkg::div_status_t div_status;

  assign cmd_stall = (state != ST_IDLE);
  assign accept    = cmd_valid && (state == ST_IDLE);
  assign toggle    = cmd.latch_data[0] ^ latch_byte[0];
  assign gap       = (cmd.cycle_time >= last_toggle_time) ?
                     (cmd.cycle_time - last_toggle_time) :
                     (last_toggle_time - cmd.cycle_time);
  assign eligible  = (last_toggle_time != '0) && (toggle_count > TW'(1)) &&
                     (gap_total != '0);
  assign res_free  = !res_valid || !res_stall;

  stfm_div #(
    .NUM_W(PROD_W)
  ) u_div (
    .clk        (clk),
    .rst        (rst),
    .start      (state == ST_DIVS),
    .numerator  (product),
    .denominator(gap_total),
    .quotient   (quotient),
    .status     (div_status)
  );

  always_ff @(posedge clk) begin
    if (state == ST_MUL) begin
      product <= HALF_RATE * toggle_count;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= ST_IDLE;
      latch_byte       <= '0;
      last_toggle_time <= '0;
      toggle_count     <= '0;
      gap_total        <= '0;
      frequency_reg    <= '0;
      res_valid        <= 1'b0;
    end else begin
      if (res_valid && !res_stall) begin
        res_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (accept) begin
            state <= ST_FIN;
            case (stfm_pkg::cmd_code_t'(cmd.command))
              stfm_pkg::CMD_WRITE: begin
                if (toggle) begin
                  if (last_toggle_time == '0) begin
                    toggle_count <= '0;
                    gap_total    <= '0;
                  end else begin
                    toggle_count <= toggle_count + TW'(1);
                    gap_total    <= gap_total + gap;
                  end
                  last_toggle_time <= cmd.cycle_time;
                end
                latch_byte <= cmd.latch_data;
              end
              stfm_pkg::CMD_SYNC: begin
                if (eligible) begin
                  state <= ST_MUL;
                end else begin
                  frequency_reg <= '0;
                end
                last_toggle_time <= '0;
              end
              stfm_pkg::CMD_RESET: begin
                latch_byte       <= '0;
                last_toggle_time <= '0;
                toggle_count     <= '0;
                gap_total        <= '0;
                frequency_reg    <= '0;
              end
              default: begin
              end
            endcase
          end
        end
        ST_MUL: begin
          state <= ST_DIVS;
        end
        ST_DIVS: begin
          state <= ST_DIVW;
        end
        ST_DIVW: begin
          if (div_status.done) begin
            frequency_reg <= div_status.saturated ? stfm_pkg::FREQ_MAX : quotient;
            state         <= ST_FIN;
          end
        end
        ST_FIN: begin
          if (res_free) begin
            res_valid <= 1'b1;
            state     <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_FIN && res_free) begin
      res.tone_frequency <= frequency_reg;
      res.latch_value    <= latch_byte;
      res.video_mode     <= latch_byte[stfm_pkg::MODE_LSB +: 2];
    end
  end

endmodule

@@ rtl/core/stfm_div.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Speaker tone frequency meter divider
// Restoring divider, one quotient bit per cycle, quotient saturated to FREQ_W.
// ----------------------------------------------------------------------------
module stfm_div #(
  parameter int NUM_W = 58
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  input  logic [NUM_W-1:0]                    numerator,
  input  logic [stfm_pkg::TIME_W-1:0]         denominator,
  output logic [stfm_pkg::FREQ_W-1:0]         quotient,
  output stfm_pkg::div_status_t               status
);

  localparam int FW    = stfm_pkg::FREQ_W;
  localparam int TW    = stfm_pkg::TIME_W;
  localparam int CNT_W = $clog2(FW);

  logic [TW-1:0]    rem;
  logic [FW-1:0]    low;
  logic [CNT_W-1:0] cnt;
  logic             busy;

  logic [TW-1:0] init_rem;
  logic [TW:0]   shifted;
  logic          ge;
  logic [TW:0]   diff;

  assign init_rem = TW'(numerator >> FW);
  assign shifted  = {rem, low[FW-1]};
  assign ge       = shifted >= {1'b0, denominator};
  assign diff     = shifted - {1'b0, denominator};
  assign quotient = low;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy   <= 1'b0;
      status <= '0;
      cnt    <= '0;
    end else begin
      status.done <= 1'b0;
      if (start) begin
        cnt <= '0;
        if (init_rem >= denominator) begin
          busy             <= 1'b0;
          status.done      <= 1'b1;
          status.saturated <= 1'b1;
        end else begin
          busy             <= 1'b1;
          status.saturated <= 1'b0;
        end
      end else if (busy) begin
        cnt <= cnt + CNT_W'(1);
        if (cnt == CNT_W'(FW - 1)) begin
          busy        <= 1'b0;
          status.done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= init_rem;
      if (init_rem >= denominator) begin
        low <= stfm_pkg::FREQ_MAX;
      end else begin
        low <= numerator[FW-1:0];
      end
    end else if (busy) begin
      rem <= ge ? diff[TW-1:0] : shifted[TW-1:0];
      low <= {low[FW-2:0], ge};
    end
  end

endmodule

@@ tb/sv/speaker_tone_frequency_meter_top_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Speaker tone frequency meter testbench
// Drives latch writes, frame syncs, resets and no-ops through the command
// channel and checks every result against a cycle-free model of the latch,
// toggle measurement and saturating frequency estimate. Runs a directed
// sequence and then random tone frames under several idle and stall mixes.
// ----------------------------------------------------------------------------
module speaker_tone_frequency_meter_top_tb;

  localparam int          RATE      = 3546900;
  localparam logic [63:0] HALF_RATE = 64'(RATE / 2);
  localparam int          PHASE_LEN = 325;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cmd_valid = 1'b0;
  logic cmd_stall;
  stfm_pkg::cmd_t cmd = '0;
  logic res_valid;
  logic res_stall = 1'b0;
  stfm_pkg::res_t res;

  stfm_pkg::cmd_t cmd_backlog[$];
  stfm_pkg::res_t expected_readouts[$];

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int fail_count     = 0;
  int items_queued   = 0;
  logic gen_spk      = 1'b0;

  // model state
  logic [7:0]                  latch_now  = '0;
  logic [stfm_pkg::TIME_W-1:0] toggle_at  = '0;
  logic [31:0]                 toggle_cnt = '0;
  logic [31:0]                 gap_sum    = '0;
  logic [stfm_pkg::FREQ_W-1:0] freq_now   = '0;

  speaker_tone_frequency_meter_top #(.CYCLES_PER_SECOND(RATE)) uut (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_stall (cmd_stall),
    .cmd       (cmd),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res       (res)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic stfm_pkg::res_t meter_step(stfm_pkg::cmd_t c);
    stfm_pkg::res_t r;
    logic [31:0]    gap;
    logic [63:0]    quot;
    case (stfm_pkg::cmd_code_t'(c.command))
      stfm_pkg::CMD_WRITE: begin
        if (c.latch_data[0] != latch_now[0]) begin
          if (toggle_at == '0) begin
            toggle_cnt = '0;
            gap_sum    = '0;
          end else begin
            gap = (c.cycle_time >= toggle_at) ? c.cycle_time - toggle_at
                                              : toggle_at - c.cycle_time;
            toggle_cnt = toggle_cnt + 32'd1;
            gap_sum    = gap_sum + gap;
          end
          toggle_at = c.cycle_time;
        end
        latch_now = c.latch_data;
      end
      stfm_pkg::CMD_SYNC: begin
        if (toggle_at != '0 && toggle_cnt > 32'd1 && gap_sum != '0) begin
          quot = (HALF_RATE * 64'(toggle_cnt)) / 64'(gap_sum);
          freq_now = (quot > 64'(stfm_pkg::FREQ_MAX)) ? stfm_pkg::FREQ_MAX
                                                      : quot[stfm_pkg::FREQ_W-1:0];
        end else begin
          freq_now = '0;
        end
        toggle_at = '0;
      end
      stfm_pkg::CMD_RESET: begin
        latch_now  = '0;
        toggle_at  = '0;
        toggle_cnt = '0;
        gap_sum    = '0;
        freq_now   = '0;
      end
      default: ;
    endcase
    r.tone_frequency = freq_now;
    r.latch_value    = latch_now;
    r.video_mode     = latch_now[stfm_pkg::MODE_LSB +: 2];
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("%0t mismatch: %s got 0x%0h want 0x%0h", $time, what, got, want);
    fail_count++;
  endtask

  task automatic push_cmd(stfm_pkg::cmd_code_t op, logic [7:0] data, logic [31:0] stamp);
    stfm_pkg::cmd_t c;
    c.command    = op;
    c.latch_data = data;
    c.cycle_time = stamp;
    if (op == stfm_pkg::CMD_WRITE) begin
      gen_spk = data[0];
    end else if (op == stfm_pkg::CMD_RESET) begin
      gen_spk = 1'b0;
    end
    cmd_backlog.push_back(c);
    items_queued++;
  endtask

  task automatic push_toggle(logic [31:0] stamp);
    logic [7:0] upper;
    upper = 8'($urandom);
    push_cmd(stfm_pkg::CMD_WRITE, {upper[7:1], ~gen_spk}, stamp);
  endtask

  task automatic queue_frame();
    int          n;
    int          kind;
    logic [31:0] stamp;
    logic [31:0] gap;
    logic [7:0]  upper;
    kind  = $urandom_range(9);
    stamp = ($urandom_range(9) == 0) ? 32'd0 : $urandom;
    n     = $urandom_range(14, 1);
    for (int k = 0; k < n; k++) begin
      if (kind == 0) begin
        gap = $urandom_range(3);
      end else if (kind == 1) begin
        gap = $urandom;
      end else begin
        gap = $urandom_range(20000, 40);
      end
      if ($urandom_range(7) == 0) begin
        upper = 8'($urandom);
        push_cmd(stfm_pkg::CMD_WRITE, {upper[7:1], gen_spk}, stamp);
      end
      push_toggle(stamp);
      stamp = ($urandom_range(15) == 0) ? stamp - gap : stamp + gap;
    end
    push_cmd(stfm_pkg::CMD_SYNC, 8'($urandom), $urandom);
  endtask

  task automatic queue_random_item();
    int pick;
    pick = $urandom_range(99);
    if (pick < 70) begin
      queue_frame();
    end else if (pick < 80) begin
      push_cmd(stfm_pkg::CMD_WRITE, 8'($urandom), $urandom);
    end else if (pick < 88) begin
      push_cmd(stfm_pkg::CMD_SYNC, 8'($urandom), $urandom);
    end else if (pick < 94) begin
      push_cmd(stfm_pkg::CMD_NOP, 8'($urandom), $urandom);
    end else begin
      push_cmd(stfm_pkg::CMD_RESET, 8'($urandom), $urandom);
    end
  endtask

  task automatic wait_drained();
    while (cmd_backlog.size() != 0 || cmd_valid || expected_readouts.size() != 0) begin
      @(negedge clk);
    end
  endtask

  // driver: predict on each accepted transfer, then present the next item
  always @(posedge clk) begin
    if (rst) begin
      cmd_valid <= 1'b0;
    end else begin
      if (cmd_valid && !cmd_stall) begin
        expected_readouts.push_back(meter_step(cmd));
      end
      if (!cmd_valid || !cmd_stall) begin
        if (cmd_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          cmd       <= cmd_backlog.pop_front();
          cmd_valid <= 1'b1;
        end else begin
          cmd_valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin : readout_monitor
    stfm_pkg::res_t want;
    if (rst) begin
      res_stall <= 1'b0;
    end else begin
      if (res_valid && !res_stall) begin
        if (expected_readouts.size() == 0) begin
          report_mismatch("unexpected result, latch", 32'(res.latch_value), 32'd0);
        end else begin
          want = expected_readouts.pop_front();
          if (res.tone_frequency !== want.tone_frequency) begin
            report_mismatch("tone_frequency", 32'(res.tone_frequency),
                            32'(want.tone_frequency));
          end
          if (res.latch_value !== want.latch_value) begin
            report_mismatch("latch_value", 32'(res.latch_value), 32'(want.latch_value));
          end
          if (res.video_mode !== want.video_mode) begin
            report_mismatch("video_mode", 32'(res.video_mode), 32'(want.video_mode));
          end
        end
      end
      res_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  initial begin
    #10_000_000;
    $display("*** FAILED ***");
    $finish;
  end

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    push_cmd(stfm_pkg::CMD_RESET, 8'hFF, 32'hFFFF_FFFF);
    push_cmd(stfm_pkg::CMD_SYNC, 8'h00, 32'h0000_0000);
    push_cmd(stfm_pkg::CMD_WRITE, 8'hFF, 32'd100);
    push_cmd(stfm_pkg::CMD_WRITE, 8'h18, 32'd0);
    push_cmd(stfm_pkg::CMD_WRITE, 8'h19, 32'd500);
    push_cmd(stfm_pkg::CMD_WRITE, 8'h08, 32'd600);
    push_cmd(stfm_pkg::CMD_WRITE, 8'h10, 32'd650);
    push_cmd(stfm_pkg::CMD_WRITE, 8'h01, 32'd700);
    push_cmd(stfm_pkg::CMD_SYNC, 8'h00, 32'd0);
    push_cmd(stfm_pkg::CMD_SYNC, 8'hFF, 32'hFFFF_FFFF);
    push_cmd(stfm_pkg::CMD_NOP, 8'hA5, 32'h5A5A_5A5A);
    // single gap, then a gap total of zero
    push_toggle(32'd50);
    push_toggle(32'd80);
    push_cmd(stfm_pkg::CMD_SYNC, 8'h00, 32'd0);
    push_toggle(32'd9);
    push_toggle(32'd9);
    push_toggle(32'd9);
    push_cmd(stfm_pkg::CMD_SYNC, 8'h00, 32'd0);
    // gap total wraps through zero
    push_toggle(32'd1);
    push_toggle(32'h8000_0001);
    push_toggle(32'd1);
    push_toggle(32'd2);
    push_cmd(stfm_pkg::CMD_SYNC, 8'h00, 32'd0);
    // saturating estimate
    for (int k = 0; k < 41; k++) begin
      push_toggle(32'd5);
    end
    push_toggle(32'd6);
    push_cmd(stfm_pkg::CMD_SYNC, 8'h00, 32'd0);
    push_cmd(stfm_pkg::CMD_RESET, 8'h00, 32'd0);
    push_toggle(32'hFFFF_FFFF);
    push_toggle(32'h0000_0010);
    push_toggle(32'hFFFF_FFF0);
    push_cmd(stfm_pkg::CMD_SYNC, 8'h00, 32'd0);

    for (int p = 0; p < 4; p++) begin
      case (p)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 73; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 73; end
        default: begin send_idle_pct = 6; recv_stall_pct = 6; end
      endcase
      while (items_queued < (p + 1) * PHASE_LEN) begin
        queue_random_item();
      end
      wait_drained();
    end

    repeat (40) @(posedge clk);
    if (expected_readouts.size() != 0) begin
      report_mismatch("results outstanding", 32'(expected_readouts.size()), 32'd0);
    end
    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
